/* hdl/bdpl_pkg.sv */
package bdpl_pkg;

   localparam int NUM_BUTTONS = 2;
   localparam int LEVEL_W     = 2;
   localparam int IDX_W       = 1;
   localparam int CNT_W       = 8;
   localparam logic [CNT_W-1:0] THRESH_RESET = CNT_W'(20);

   // stream payload widths
   localparam int REQ_FIELD_W = LEVEL_W + IDX_W;
   localparam int REQ_DATA_W  = ((REQ_FIELD_W + 7) / 8) * 8;
   localparam int RSP_FIELD_W = 1 + LEVEL_W + LEVEL_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_TAKE    = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_CAPTURE = 2'd3
   } cmd_type;

   // post-step view of one button
   typedef struct packed {
      logic stable;
      logic press;
      logic taken;
   } lane_out_type;

endpackage

/* hdl/button_debounce_press_latch_top.sv */
// debouncer with press latch for a row of push buttons
// request channel: req_tuser carries the command (tick, take press, clear
// all presses, capture levels), req_tdata the raw levels and the button
// index used by take press
// response channel: one response per request with the taken flag, the
// debounced levels and the latched presses as they stand after the request
// csr port: csr_wr_en writes the debounce threshold in ticks; the user must write it
// only while idle, the block does not enforce this; every button has its own lane
// (level, counter, press flag) and all lanes step in the same cycle; the merge stage
// packs them into the response register, valid in the cycle after the request is accepted
// throughput: one request per cycle while responses are taken, set by the single response register;
// a new request is taken in the same cycle the previous response leaves
// when the receiver stalls, the response holds and req_tready drops until
// the response is taken
// reset: levels, counters and press flags clear, threshold returns to 20,
// no response is pending
module button_debounce_press_latch_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bdpl_pkg::REQ_DATA_W-1:0]    req_tdata,  // raw_levels, button_index, pad
   input  logic [1:0]                         req_tuser,  // cmd
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bdpl_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // press_taken, stable_levels,
                                                          // pending_presses, pad
   input  logic                               csr_wr_en,
   input  logic [bdpl_pkg::CNT_W-1:0]         csr_wr_data
);

   logic [bdpl_pkg::CNT_W-1:0]   thresh_ff, thresh_in;
   logic                         step_en;
   logic                         slot_free;
   bdpl_pkg::cmd_type            cmd;
   logic [bdpl_pkg::LEVEL_W-1:0] raw_levels;
   logic [bdpl_pkg::IDX_W-1:0]   button_index;
   bdpl_pkg::lane_out_type       lanes [bdpl_pkg::NUM_BUTTONS];

   assign cmd          = bdpl_pkg::cmd_type'(req_tuser);
   assign raw_levels   = req_tdata[bdpl_pkg::LEVEL_W-1:0];
   assign button_index = req_tdata[bdpl_pkg::LEVEL_W +: bdpl_pkg::IDX_W];

   assign req_tready = slot_free;
   assign step_en    = req_tvalid && slot_free;

   // threshold register
   assign thresh_in = csr_wr_en ? csr_wr_data : thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= bdpl_pkg::THRESH_RESET;
      end else begin
         thresh_ff <= thresh_in;
      end
   end

   // one lane per button
   for (genvar b = 0; b < bdpl_pkg::NUM_BUTTONS; b++) begin : g_lane
      logic raw_bit;
      logic take_sel;

      // buttons above the levels field read low
      if (b < bdpl_pkg::LEVEL_W) begin : g_raw
         assign raw_bit = raw_levels[b];
      end else begin : g_raw_zero
         assign raw_bit = 1'b0;
      end

      assign take_sel = (32'(button_index) == 32'(b));

      bdpl_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .step_en   (step_en),
         .cmd       (cmd),
         .raw_bit   (raw_bit),
         .take_sel  (take_sel),
         .threshold (thresh_ff),
         .lane_out  (lanes[b])
      );
   end

   // pack lanes into the response register
   bdpl_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .step_en    (step_en),
      .lanes      (lanes),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .slot_free  (slot_free)
   );

   // clear all presses leaves nothing pending
   assert property (@(posedge clock) disable iff (reset)
      step_en && cmd == bdpl_pkg::CMD_CLEAR
      |=> rsp_tdata[1 + bdpl_pkg::LEVEL_W +: bdpl_pkg::LEVEL_W] == '0)
      else $error("presses pending after clear");

   // capture copies the raw levels into the stable levels
   assert property (@(posedge clock) disable iff (reset)
      step_en && cmd == bdpl_pkg::CMD_CAPTURE
      |=> rsp_tdata[1 +: bdpl_pkg::LEVEL_W] == $past(raw_levels))
      else $error("stable levels differ from captured raw levels");

   // only a take press request can report a taken press
   assert property (@(posedge clock) disable iff (reset)
      step_en && cmd != bdpl_pkg::CMD_TAKE |=> !rsp_tdata[0])
      else $error("press taken without a take request");

   // a stalled response blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted over a stalled response");

endmodule

/* hdl/bdpl_lane.sv */
module bdpl_lane (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  bdpl_pkg::cmd_type        cmd,
   input  logic                     raw_bit,
   input  logic                     take_sel,
   input  logic [bdpl_pkg::CNT_W-1:0] threshold,
   output bdpl_pkg::lane_out_type   lane_out
);

   logic                       stable_ff, stable_in;
   logic                       press_ff, press_in;
   logic [bdpl_pkg::CNT_W-1:0] count_ff, count_in;
   logic [bdpl_pkg::CNT_W-1:0] count_inc;
   logic                       taken;

   assign count_inc = count_ff + bdpl_pkg::CNT_W'(1);

   always_comb begin
      stable_in = stable_ff;
      press_in  = press_ff;
      count_in  = count_ff;
      taken     = 1'b0;
      unique case (cmd)
         bdpl_pkg::CMD_TICK: begin
            if (raw_bit == stable_ff) begin
               count_in = '0;
            end else if (count_inc >= threshold) begin
               // level held long enough, accept it
               stable_in = raw_bit;
               count_in  = '0;
               if (raw_bit) begin
                  press_in = 1'b1;
               end
            end else begin
               count_in = count_inc;
            end
         end
         bdpl_pkg::CMD_TAKE: begin
            if (take_sel && press_ff) begin
               press_in = 1'b0;
               taken    = 1'b1;
            end
         end
         bdpl_pkg::CMD_CLEAR: begin
            press_in = 1'b0;
         end
         bdpl_pkg::CMD_CAPTURE: begin
            stable_in = raw_bit;
         end
         default: begin
            stable_in = stable_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stable_ff <= 1'b0;
         press_ff  <= 1'b0;
         count_ff  <= '0;
      end else if (step_en) begin
         stable_ff <= stable_in;
         press_ff  <= press_in;
         count_ff  <= count_in;
      end
   end

   assign lane_out.stable = stable_in;
   assign lane_out.press  = press_in;
   assign lane_out.taken  = taken;

endmodule

/* hdl/bdpl_merge.sv */
module bdpl_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              step_en,
   input  bdpl_pkg::lane_out_type            lanes [bdpl_pkg::NUM_BUTTONS],
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [bdpl_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              slot_free
);

   logic                                 valid_ff, valid_in;
   logic [bdpl_pkg::RSP_DATA_W-1:0]      data_ff, data_in;
   logic [bdpl_pkg::LEVEL_W-1:0]         stable_bits;
   logic [bdpl_pkg::LEVEL_W-1:0]         press_bits;
   logic                                 any_taken;

   // only the low buttons are reported
   for (genvar b = 0; b < bdpl_pkg::LEVEL_W; b++) begin : g_pack
      if (b < bdpl_pkg::NUM_BUTTONS) begin : g_used
         assign stable_bits[b] = lanes[b].stable;
         assign press_bits[b]  = lanes[b].press;
      end else begin : g_empty
         assign stable_bits[b] = 1'b0;
         assign press_bits[b]  = 1'b0;
      end
   end

   always_comb begin
      any_taken = 1'b0;
      for (int b = 0; b < bdpl_pkg::NUM_BUTTONS; b++) begin
         any_taken = any_taken | lanes[b].taken;
      end
   end

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (step_en) begin
         valid_in = 1'b1;
         data_in  = bdpl_pkg::RSP_DATA_W'({press_bits, stable_bits, any_taken});
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

/* tb/debounce_checker.sv */
`timescale 1ns / 1ps

module debounce_checker
   import bdpl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // raw_levels, button_index, pad
   input  logic [1:0]            req_tuser,   // cmd
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // press_taken, stable_levels,
                                              // pending_presses, pad
   input  logic                  csr_wr_en,
   input  logic [CNT_W-1:0]      csr_wr_data,
   output int                    fail_count,
   output int                    outstanding
);

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [LEVEL_W-1:0] raw;
   } req_fields_t;

   typedef struct packed {
      logic [LEVEL_W-1:0] presses;
      logic [LEVEL_W-1:0] levels;
      logic               taken;
   } button_view_t;

   logic [CNT_W-1:0]       threshold;
   logic [NUM_BUTTONS-1:0] stable_lvl;
   logic [NUM_BUTTONS-1:0] press_flag;
   logic [CNT_W-1:0]       miss_cnt [NUM_BUTTONS];
   button_view_t           expected_views [$];
   int                     fails = 0;

   task automatic step_debouncer(input cmd_type cmd, input logic [LEVEL_W-1:0] raw,
                                 input logic [IDX_W-1:0] idx, output button_view_t view);
      logic r;
      view = '0;
      case (cmd)
         CMD_TICK: begin
            for (int b = 0; b < NUM_BUTTONS; b++) begin
               r = (b < LEVEL_W) ? raw[b] : 1'b0;
               if (r == stable_lvl[b]) begin
                  miss_cnt[b] = '0;
               end else begin
                  miss_cnt[b] = miss_cnt[b] + 1'b1;
                  if (miss_cnt[b] >= threshold) begin
                     stable_lvl[b] = r;
                     miss_cnt[b]   = '0;
                     if (r) press_flag[b] = 1'b1;
                  end
               end
            end
         end
         CMD_TAKE: begin
            if (int'(idx) < NUM_BUTTONS && press_flag[idx]) begin
               press_flag[idx] = 1'b0;
               view.taken      = 1'b1;
            end
         end
         CMD_CLEAR: begin
            press_flag = '0;
         end
         CMD_CAPTURE: begin
            for (int b = 0; b < NUM_BUTTONS; b++)
               stable_lvl[b] = (b < LEVEL_W) ? raw[b] : 1'b0;
         end
      endcase
      for (int b = 0; b < LEVEL_W && b < NUM_BUTTONS; b++) begin
         view.levels[b]  = stable_lvl[b];
         view.presses[b] = press_flag[b];
      end
   endtask

   always @(posedge clock) begin : monitor
      button_view_t view;
      button_view_t got;
      req_fields_t  rq;
      if (reset) begin
         threshold  = THRESH_RESET;
         stable_lvl = '0;
         press_flag = '0;
         for (int b = 0; b < NUM_BUTTONS; b++) miss_cnt[b] = '0;
         expected_views.delete();
      end else begin
         if (csr_wr_en) threshold = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = button_view_t'(rsp_tdata[RSP_FIELD_W-1:0]);
            if (expected_views.size() == 0) begin
               $error("response with no request waiting: %h", rsp_tdata);
               fails++;
            end else begin
               view = expected_views.pop_front();
               if (got.taken !== view.taken) begin
                  $error("press_taken mismatch: expected %0d, got %0d", view.taken, got.taken);
                  fails++;
               end
               if (got.levels !== view.levels) begin
                  $error("stable_levels mismatch: expected %b, got %b",
                         view.levels, got.levels);
                  fails++;
               end
               if (got.presses !== view.presses) begin
                  $error("pending_presses mismatch: expected %b, got %b",
                         view.presses, got.presses);
                  fails++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            rq = req_fields_t'(req_tdata[REQ_FIELD_W-1:0]);
            step_debouncer(cmd_type'(req_tuser), rq.raw, rq.idx, view);
            expected_views.push_back(view);
         end
      end
      fail_count  <= fails;
      outstanding <= expected_views.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
   import bdpl_pkg::*;

   localparam int ITEM_TARGET = 1950;
   localparam int HOLD_CYCLES = 150;   // long receiver stall, fills the response register
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;   // raw_levels, button_index, pad
   logic [1:0]            req_tuser   = '0;   // cmd
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // press_taken, stable_levels,
                                              // pending_presses, pad
   logic                  csr_wr_en   = 1'b0;
   logic [CNT_W-1:0]      csr_wr_data = '0;

   int fail_count;
   int outstanding;
   int cycles         = 0;
   int items_sent     = 0;
   int thresholds_set = 0;
   bit no_idle        = 1'b0;   // both sides run back to back
   int hold_len       = 0;      // set once by the stimulus, served once by the receiver
   bit hold_done      = 1'b0;

   always #1 clock = ~clock;

   button_debounce_press_latch_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // watches both channels and the csr port, predicts every response
   debounce_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses missing", cycles, outstanding);
         $display("FAILURE");
         $finish;
      end
   end

   // response side: random stall per response, one long hold when asked
   initial begin : receiver
      int stall;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_len != 0 && !hold_done) begin
            stall     = hold_len;
            hold_done = 1'b1;
         end else if (no_idle) begin
            stall = 0;
         end else begin
            stall = $urandom_range(0, 4);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // offer one request and hold it until taken; valid stays up when no gap follows
   task automatic send(input cmd_type cmd, input logic [LEVEL_W-1:0] raw,
                       input logic [IDX_W-1:0] idx);
      int gap;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_W'({idx, raw});
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // stop offering and wait until every response is back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // threshold only changes while the block is idle
   task automatic set_threshold(input int ticks);
      drain();
      csr_wr_data <= CNT_W'(ticks);
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      thresholds_set++;
   endtask

   // a steady raw level held for about the threshold, with the odd bounce,
   // followed now and then by a take, a clear or a capture
   task automatic debounce_run(input int thr);
      logic [LEVEL_W-1:0] lvl;
      int                 len;
      int                 base;
      base = (thr < 1) ? 1 : thr;
      lvl  = LEVEL_W'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0:       len = base - 1;
         1:       len = base;
         2:       len = base + 1;
         default: len = $urandom_range(1, 2 * base + 2);
      endcase
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 11) == 0)
            send(CMD_TICK, LEVEL_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 1)));
         else
            send(CMD_TICK, lvl, IDX_W'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 1) == 0)
         send(CMD_TAKE, LEVEL_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0)
         send(CMD_TAKE, LEVEL_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 7) == 0)
         send(CMD_CLEAR, LEVEL_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 1)));
      if ($urandom_range(0, 9) == 0)
         send(CMD_CAPTURE, LEVEL_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 1)));
   endtask

   initial begin : stimulus
      int phase;
      int thr;
      phase = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset threshold of 20: buttons held at start-up are captured, not pressed
      send(CMD_CAPTURE, 2'b11, 1'b0);
      send(CMD_TAKE, 2'b00, 1'b0);
      send(CMD_TAKE, 2'b11, 1'b1);
      repeat (3) send(CMD_TICK, 2'b00, 1'b0);
      send(CMD_TICK, 2'b11, 1'b1);            // matching level clears the count
      send(CMD_CLEAR, 2'b10, 1'b1);

      // threshold of 1: every differing tick is taken at once
      set_threshold(1);
      send(CMD_TICK, 2'b00, 1'b0);            // both fall, no press
      send(CMD_TICK, 2'b11, 1'b0);            // both rise, presses latched
      send(CMD_TAKE, 2'b00, 1'b0);
      send(CMD_TAKE, 2'b00, 1'b0);            // already taken
      send(CMD_TAKE, 2'b01, 1'b1);
      send(CMD_TICK, 2'b01, 1'b0);
      send(CMD_TICK, 2'b11, 1'b1);
      send(CMD_CLEAR, 2'b00, 1'b0);
      send(CMD_TAKE, 2'b00, 1'b1);
      send(CMD_CAPTURE, 2'b00, 1'b1);
      send(CMD_TICK, 2'b10, 1'b0);

      // threshold of zero is out of range but behaves like one
      set_threshold(0);
      send(CMD_TICK, 2'b11, 1'b0);
      send(CMD_TICK, 2'b00, 1'b1);
      send(CMD_TAKE, 2'b00, 1'b0);
      send(CMD_CLEAR, 2'b11, 1'b0);

      // largest threshold: one tick short, a bounce back, then the full count
      set_threshold(255);
      send(CMD_CAPTURE, 2'b00, 1'b0);
      repeat (254) send(CMD_TICK, 2'b11, 1'b0);
      send(CMD_TICK, 2'b00, 1'b1);
      repeat (255) send(CMD_TICK, 2'b11, 1'b1);
      send(CMD_TAKE, 2'b00, 1'b0);
      send(CMD_TAKE, 2'b00, 1'b1);

      // random phases, mostly small thresholds so that levels change often
      while (items_sent < ITEM_TARGET) begin
         phase++;
         case ($urandom_range(0, 9))
            0:       thr = 1;
            1:       thr = 0;
            2:       thr = $urandom_range(9, 40);
            default: thr = $urandom_range(2, 8);
         endcase
         set_threshold(thr);
         no_idle = (phase % 4 == 1) || (phase == 2);
         // the receiver holds off while requests keep coming back to back
         if (phase == 2) hold_len = HOLD_CYCLES;
         repeat (12) debounce_run(thr);
      end

      drain();
      repeat (4) @(posedge clock);
      $display("ran %0d requests over %0d threshold settings, all four commands",
               items_sent, thresholds_set);
      $display("thresholds 0, 1, 20 and 255 included, plus one %0d-cycle response hold",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
